### hdl/assert_macros.svh
// Assertion macros used by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define SWND_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in this cycle implies a consequence in the next one.
`define SWND_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/swnd_pkg.sv
// Types and constants of the sync word nibble deframer.
package swnd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_START = 3'd1,
        PH_DATA  = 3'd2,
        PH_STOP1 = 3'd3,
        PH_STOP2 = 3'd4
    } phase_t;

    localparam logic [1:0] CFG_SYNC_MODE    = 2'd0;
    localparam logic [1:0] CFG_SYNC_PATTERN = 2'd1;
    localparam logic [1:0] CFG_PACKET_BYTES = 2'd2;

    localparam logic        SYNC_MODE_RESET    = 1'b1;
    localparam logic [15:0] SYNC_PATTERN_RESET = 16'hECA1;
    localparam logic [7:0]  PACKET_BYTES_RESET = 8'd16;
    localparam logic [15:0] HUNT_RESET         = 16'hFFFF;
    localparam logic [1:0]  LAST_DATA_BIT      = 2'd3;

endpackage

### hdl/sync_word_nibble_deframer_unit.sv
// Sync word nibble deframer: serial bits in, framed bytes out.
//
// Input channel: in_valid / in_stall carry one sampled serial bit (data_bit)
// per request. Output channel: out_valid / out_stall carry one byte
// (byte_value, first nibble in bits 3..0) and last_byte, set on the final
// byte of a packet.
// Configuration: cfg_write_en with cfg_index (0 sync_mode, 1 sync_pattern,
// 2 packet_bytes) and cfg_data; the user must write only while the block is
// idle, as the block does not enforce it. Throughput: one bit per cycle while
// in_stall is low. The frame state updates in the cycle a bit is accepted; a
// byte it completes goes to the output register, or to the skid when stalled.
// When the receiver stalls, the output register holds its byte and one more
// byte fits in a skid register; in_stall rises only while the skid register
// is full, so the bit stream keeps flowing across a short stall.
// Reset: registers return to sync mode, pattern 0xeca1, 16 bytes per packet,
// hunt register all ones, hunting for the sync word, both output slots empty.
`include "assert_macros.svh"

module sync_word_nibble_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        data_bit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_value,
    output logic        last_byte,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration
    logic        sync_mode_reg;
    logic [15:0] sync_pattern_reg;
    logic [7:0]  packet_bytes_reg;

    // frame state
    swnd_pkg::phase_t phase_reg, phase_next, eff_phase;
    logic [15:0] hunt_shift_reg, hunt_shift_next;
    logic [1:0]  bit_index_reg, bit_index_next;
    logic [3:0]  nibble_shift_reg, nibble_shift_next;
    logic [3:0]  low_nibble_reg, low_nibble_next;
    logic        high_half_reg, high_half_next;
    logic [7:0]  byte_index_reg, byte_index_next;

    // output register and skid
    logic        out_valid_reg, skid_valid_reg;
    logic [7:0]  out_byte_reg, skid_byte_reg;
    logic        out_last_reg, skid_last_reg;

    logic        accept;
    logic        out_fire;
    logic [3:0]  shifted;
    logic        nibble_done;
    logic        last;
    logic        res_valid;
    logic [7:0]  res_byte;
    logic [15:0] hunt_shifted;
    logic        idle_is_hunt;

    assign in_stall   = skid_valid_reg;
    assign accept     = in_valid && !in_stall;
    assign out_fire   = out_valid_reg && !out_stall;
    assign out_valid  = out_valid_reg;
    assign byte_value = out_byte_reg;
    assign last_byte  = out_last_reg;

    assign idle_is_hunt = sync_mode_reg;
    assign eff_phase = (phase_reg == swnd_pkg::PH_HUNT && !sync_mode_reg)
                       ? swnd_pkg::PH_START : phase_reg;
    assign shifted      = {data_bit, nibble_shift_reg[3:1]};
    assign hunt_shifted = {hunt_shift_reg[14:0], data_bit};

    // a nibble closes at the fourth data bit in free mode, at the second
    // stop mark in sync mode
    assign nibble_done =
        (eff_phase == swnd_pkg::PH_DATA && bit_index_reg == swnd_pkg::LAST_DATA_BIT
            && !sync_mode_reg)
        || (eff_phase == swnd_pkg::PH_STOP2 && data_bit);
    // packet_bytes of zero behaves as one
    assign last = ({1'b0, byte_index_reg} + 9'd1) >= {1'b0, packet_bytes_reg};
    assign res_valid = nibble_done && high_half_reg;
    assign res_byte  = (eff_phase == swnd_pkg::PH_DATA)
                       ? {shifted, low_nibble_reg} : {nibble_shift_reg, low_nibble_reg};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (eff_phase)
            swnd_pkg::PH_HUNT:
            begin
                if (hunt_shifted == sync_pattern_reg)
                    phase_next = swnd_pkg::PH_START;
            end
            swnd_pkg::PH_START:
            begin
                phase_next = data_bit ? swnd_pkg::PH_START : swnd_pkg::PH_DATA;
            end
            swnd_pkg::PH_DATA:
            begin
                if (bit_index_reg == swnd_pkg::LAST_DATA_BIT)
                begin
                    if (sync_mode_reg)
                        phase_next = swnd_pkg::PH_STOP1;
                    else if (high_half_reg && last)
                        phase_next = swnd_pkg::PH_HUNT;  // free mode: idle is start
                    else
                        phase_next = swnd_pkg::PH_START;
                end
            end
            swnd_pkg::PH_STOP1:
            begin
                if (data_bit)
                    phase_next = swnd_pkg::PH_STOP2;
            end
            swnd_pkg::PH_STOP2:
            begin
                if (data_bit)
                begin
                    if (high_half_reg && last && idle_is_hunt)
                        phase_next = swnd_pkg::PH_HUNT;
                    else
                        phase_next = swnd_pkg::PH_START;
                end
            end
            default:
            begin
                phase_next = idle_is_hunt ? swnd_pkg::PH_HUNT : swnd_pkg::PH_START;
            end
        endcase
        // hunt with sync mode off acts as start, so parking in hunt is harmless
        if (phase_next == swnd_pkg::PH_HUNT && !idle_is_hunt)
            phase_next = swnd_pkg::PH_START;
    end

    // datapath
    always_comb
    begin
        hunt_shift_next   = hunt_shift_reg;
        bit_index_next    = bit_index_reg;
        nibble_shift_next = nibble_shift_reg;
        low_nibble_next   = low_nibble_reg;
        high_half_next    = high_half_reg;
        byte_index_next   = byte_index_reg;
        case (eff_phase)
            swnd_pkg::PH_HUNT:
            begin
                hunt_shift_next = hunt_shifted;
                if (hunt_shifted == sync_pattern_reg)
                begin
                    byte_index_next = 8'd0;
                    high_half_next  = 1'b0;
                end
            end
            swnd_pkg::PH_START:
            begin
                if (!data_bit)
                begin
                    bit_index_next    = 2'd0;
                    nibble_shift_next = 4'd0;
                end
            end
            swnd_pkg::PH_DATA:
            begin
                nibble_shift_next = shifted;
                bit_index_next    = bit_index_reg + 2'd1;  // wraps to 0 after the last
            end
            default:
            begin
            end
        endcase
        if (nibble_done)
        begin
            if (!high_half_reg)
            begin
                low_nibble_next = (eff_phase == swnd_pkg::PH_DATA) ? shifted : nibble_shift_reg;
                high_half_next  = 1'b1;
            end
            else
            begin
                high_half_next = 1'b0;
                if (last)
                begin
                    byte_index_next = 8'd0;
                    hunt_shift_next = swnd_pkg::HUNT_RESET;
                end
                else
                    byte_index_next = byte_index_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_mode_reg    <= swnd_pkg::SYNC_MODE_RESET;
            sync_pattern_reg <= swnd_pkg::SYNC_PATTERN_RESET;
            packet_bytes_reg <= swnd_pkg::PACKET_BYTES_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                swnd_pkg::CFG_SYNC_MODE:    sync_mode_reg    <= cfg_data[0];
                swnd_pkg::CFG_SYNC_PATTERN: sync_pattern_reg <= cfg_data;
                swnd_pkg::CFG_PACKET_BYTES: packet_bytes_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= swnd_pkg::PH_HUNT;
            hunt_shift_reg   <= swnd_pkg::HUNT_RESET;
            bit_index_reg    <= 2'd0;
            nibble_shift_reg <= 4'd0;
            low_nibble_reg   <= 4'd0;
            high_half_reg    <= 1'b0;
            byte_index_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            hunt_shift_reg   <= hunt_shift_next;
            bit_index_reg    <= bit_index_next;
            nibble_shift_reg <= nibble_shift_next;
            low_nibble_reg   <= low_nibble_next;
            high_half_reg    <= high_half_next;
            byte_index_reg   <= byte_index_next;
        end
    end

    // output slot with one-deep skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= accept && res_valid;
        end
        else if (accept && res_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_byte_reg <= skid_byte_reg;
                out_last_reg <= skid_last_reg;
            end
            else
            begin
                out_byte_reg <= res_byte;
                out_last_reg <= last;
            end
        end
        else if (accept && res_valid)
        begin
            skid_byte_reg <= res_byte;
            skid_last_reg <= last;
        end
    end

    `SWND_ASSERT(a_skid_needs_out, !skid_valid_reg || out_valid_reg,
        "skid holds a byte while the output slot is empty")
    `SWND_ASSERT_NEXT(a_stalled_result_to_skid,
        out_valid_reg && out_stall && accept && res_valid, skid_valid_reg,
        "byte lost while the output was stalled")
    `SWND_ASSERT(a_bit_index_in_data, phase_reg == swnd_pkg::PH_DATA || bit_index_reg == 2'd0,
        "bit index nonzero outside the data phase")
    `SWND_ASSERT_NEXT(a_last_ends_packet, accept && res_valid && last,
        byte_index_reg == 8'd0 && !high_half_reg,
        "packet state not cleared after the last byte")
    `SWND_ASSERT(a_result_phase,
        !res_valid || eff_phase == swnd_pkg::PH_DATA || eff_phase == swnd_pkg::PH_STOP2,
        "byte produced outside data or second stop phase")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the sync word nibble deframer: bit stream in, framed bytes out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_WAIT   = 4;
    localparam int RANDOM_BITS  = 400;
    localparam int PRESS_BYTES  = 6;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    typedef enum {ROW_CFG, ROW_SYNC, ROW_BYTE, ROW_RAW} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [15:0] arg;
        int          len;
        logic        listed;
        logic [7:0]  exp_value;
        logic        exp_last;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        data_bit;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic        cfg_write_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // predictor state and its copy of the registers
    logic              mode_r;
    logic [15:0]       pattern_r;
    logic [7:0]        pkt_len_r;
    logic [15:0]       hunt_reg;
    swnd_pkg::phase_t  cur_phase;
    logic [1:0]        bit_cnt;
    logic [3:0]        nib_sh;
    logic [3:0]        low_nib;
    logic              second_half;
    logic [7:0]        byte_cnt;

    frame_byte_t pending_bytes[$];
    frame_byte_t listed_bytes[$];
    int          mismatches = 0;
    int          bits_sent = 0;
    int          calm_left = 0;
    bit          hold_req = 1'b0;

    // short hand-checked sequence; listed rows carry their expected byte
    row_t plan [26] = '{
        '{ROW_CFG,  swnd_pkg::CFG_PACKET_BYTES, 16'd2,      0,  1'b0, 8'h00, 1'b0},
        '{ROW_SYNC, swnd_pkg::CFG_SYNC_MODE,    16'h0000,   0,  1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, swnd_pkg::CFG_SYNC_MODE,    16'h0000,   0,  1'b1, 8'h00, 1'b0},
        '{ROW_BYTE, swnd_pkg::CFG_SYNC_MODE,    16'h00FF,   0,  1'b1, 8'hFF, 1'b1},
        '{ROW_CFG,  swnd_pkg::CFG_SYNC_PATTERN, 16'h0000,   0,  1'b0, 8'h00, 1'b0},
        '{ROW_SYNC, swnd_pkg::CFG_SYNC_MODE,    16'h0000,   0,  1'b0, 8'h00, 1'b0},
        '{ROW_CFG,  swnd_pkg::CFG_PACKET_BYTES, 16'd0,      0,  1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, swnd_pkg::CFG_SYNC_MODE,    16'h00A5,   0,  1'b1, 8'hA5, 1'b1},
        '{ROW_CFG,  swnd_pkg::CFG_SYNC_PATTERN, 16'hFFFF,   0,  1'b0, 8'h00, 1'b0},
        '{ROW_SYNC, swnd_pkg::CFG_SYNC_MODE,    16'h0000,   0,  1'b0, 8'h00, 1'b0},
        '{ROW_CFG,  swnd_pkg::CFG_PACKET_BYTES, 16'd255,    0,  1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, swnd_pkg::CFG_SYNC_MODE,    16'h003C,   0,  1'b1, 8'h3C, 1'b0},
        // low nibble 9 with idle ones and zeros before each stop mark
        '{ROW_RAW,  swnd_pkg::CFG_SYNC_MODE,    16'h0A4B,   12, 1'b0, 8'h00, 1'b0},
        // shorter packet while one is running: next byte is the last
        '{ROW_CFG,  swnd_pkg::CFG_PACKET_BYTES, 16'd1,      0,  1'b0, 8'h00, 1'b0},
        '{ROW_RAW,  swnd_pkg::CFG_SYNC_MODE,    16'h006C,   7,  1'b1, 8'h69, 1'b1},
        // free mode while hunting
        '{ROW_CFG,  swnd_pkg::CFG_SYNC_MODE,    16'd0,      0,  1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, swnd_pkg::CFG_SYNC_MODE,    16'h0096,   0,  1'b1, 8'h96, 1'b1},
        '{ROW_CFG,  swnd_pkg::CFG_PACKET_BYTES, 16'd3,      0,  1'b0, 8'h00, 1'b0},
        '{ROW_BYTE, swnd_pkg::CFG_SYNC_MODE,    16'h005A,   0,  1'b0, 8'h00, 1'b0},
        // mode flips in the middle of the data bits, then of the stop marks
        '{ROW_RAW,  swnd_pkg::CFG_SYNC_MODE,    16'h0000,   3,  1'b0, 8'h00, 1'b0},
        '{ROW_CFG,  swnd_pkg::CFG_SYNC_MODE,    16'd1,      0,  1'b0, 8'h00, 1'b0},
        '{ROW_RAW,  swnd_pkg::CFG_SYNC_MODE,    16'h001B,   5,  1'b0, 8'h00, 1'b0},
        '{ROW_RAW,  swnd_pkg::CFG_SYNC_MODE,    16'h002E,   6,  1'b0, 8'h00, 1'b0},
        '{ROW_CFG,  swnd_pkg::CFG_SYNC_MODE,    16'd0,      0,  1'b0, 8'h00, 1'b0},
        '{ROW_RAW,  swnd_pkg::CFG_SYNC_MODE,    16'h0002,   2,  1'b1, 8'h7C, 1'b0},
        '{ROW_BYTE, swnd_pkg::CFG_SYNC_MODE,    16'h00E1,   0,  1'b1, 8'hE1, 1'b1}
    };

    sync_word_nibble_deframer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_bit     (data_bit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_deframer();
        mode_r      = swnd_pkg::SYNC_MODE_RESET;
        pattern_r   = swnd_pkg::SYNC_PATTERN_RESET;
        pkt_len_r   = swnd_pkg::PACKET_BYTES_RESET;
        hunt_reg    = swnd_pkg::HUNT_RESET;
        cur_phase   = swnd_pkg::PH_HUNT;
        bit_cnt     = '0;
        nib_sh      = '0;
        low_nib     = '0;
        second_half = 1'b0;
        byte_cnt    = '0;
    endfunction

    function automatic logic close_nibble(output frame_byte_t res);
        logic [8:0] next_cnt;
        res = '0;
        if (!second_half)
        begin
            low_nib     = nib_sh;
            second_half = 1'b1;
            cur_phase   = swnd_pkg::PH_START;
            return 1'b0;
        end
        next_cnt    = {1'b0, byte_cnt} + 9'd1;
        res.value   = {nib_sh, low_nib};
        res.last    = (next_cnt >= {1'b0, pkt_len_r});
        second_half = 1'b0;
        if (res.last)
        begin
            byte_cnt  = '0;
            hunt_reg  = swnd_pkg::HUNT_RESET;
            cur_phase = mode_r ? swnd_pkg::PH_HUNT : swnd_pkg::PH_START;
        end
        else
        begin
            byte_cnt  = next_cnt[7:0];
            cur_phase = swnd_pkg::PH_START;
        end
        return 1'b1;
    endfunction

    function automatic void deframe_bit(input logic b);
        swnd_pkg::phase_t ph;
        frame_byte_t      res;
        logic             got;
        ph  = cur_phase;
        got = 1'b0;
        res = '0;
        // hunting without sync mode behaves like waiting for a start bit
        if (ph == swnd_pkg::PH_HUNT && !mode_r)
            ph = swnd_pkg::PH_START;
        case (ph)
            swnd_pkg::PH_HUNT:
            begin
                hunt_reg = {hunt_reg[14:0], b};
                if (hunt_reg == pattern_r)
                begin
                    cur_phase   = swnd_pkg::PH_START;
                    byte_cnt    = '0;
                    second_half = 1'b0;
                end
            end
            swnd_pkg::PH_START:
            begin
                if (!b)
                begin
                    cur_phase = swnd_pkg::PH_DATA;
                    bit_cnt   = '0;
                    nib_sh    = '0;
                end
                else
                    cur_phase = swnd_pkg::PH_START;
            end
            swnd_pkg::PH_DATA:
            begin
                nib_sh = {b, nib_sh[3:1]};
                if (bit_cnt != swnd_pkg::LAST_DATA_BIT)
                    bit_cnt = bit_cnt + 2'd1;
                else
                begin
                    bit_cnt = '0;
                    if (mode_r)
                        cur_phase = swnd_pkg::PH_STOP1;
                    else
                        got = close_nibble(res);
                end
            end
            swnd_pkg::PH_STOP1:
            begin
                if (b)
                    cur_phase = swnd_pkg::PH_STOP2;
            end
            swnd_pkg::PH_STOP2:
            begin
                if (b)
                    got = close_nibble(res);
            end
            default:
                cur_phase = mode_r ? swnd_pkg::PH_HUNT : swnd_pkg::PH_START;
        endcase
        if (got)
        begin
            if (listed_bytes.size() != 0)
                res = listed_bytes.pop_front();
            pending_bytes.push_back(res);
        end
    endfunction

    // checks delivered bytes, then feeds the accepted bit to the predictor
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $error("byte_value: nothing expected, got %h", byte_value);
                    mismatches++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (byte_value !== want.value)
                    begin
                        $error("byte_value: expected %h, got %h", want.value, byte_value);
                        mismatches++;
                    end
                    if (last_byte !== want.last)
                    begin
                        $error("last_byte: expected %b, got %b", want.last, last_byte);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                deframe_bit(data_bit);
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3)
            calm_left = $urandom_range(20, 60);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic drive_bit(input logic b);
        int gap;
        in_valid <= 1'b1;
        data_bit <= b;
        do
            @(posedge clk);
        while (in_stall);
        bits_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n) drive_bit(1'($urandom_range(1)));
    endtask

    task automatic send_sync();
        for (int i = 15; i >= 0; i--)
            drive_bit(pattern_r[i]);
    endtask

    // two nibbles, low first; idle ones before start, stray zeros before stop marks
    task automatic send_frame_byte(input logic [7:0] value, input int idle_max,
                                   input int noise_max);
        logic [3:0] nib;
        for (int half = 0; half < 2; half++)
        begin
            nib = half ? value[7:4] : value[3:0];
            repeat ($urandom_range(idle_max)) drive_bit(1'b1);
            drive_bit(1'b0);
            for (int k = 0; k < 4; k++)
                drive_bit(nib[k]);
            if (mode_r)
                repeat (2)
                begin
                    repeat ($urandom_range(noise_max)) drive_bit(1'b0);
                    drive_bit(1'b1);
                end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        case (idx)
            swnd_pkg::CFG_SYNC_MODE:    mode_r    = val[0];
            swnd_pkg::CFG_SYNC_PATTERN: pattern_r = val;
            swnd_pkg::CFG_PACKET_BYTES: pkt_len_r = val[7:0];
            default: ;
        endcase
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_packet();
        int nb;
        int cut;
        if ($urandom_range(4) == 0)
            send_noise($urandom_range(1, 12));
        if (mode_r)
        begin
            repeat ($urandom_range(3)) drive_bit(1'b1);
            send_sync();
        end
        nb  = (pkt_len_r == 0) ? 1 : pkt_len_r;
        // now and then a packet is cut short and followed by junk
        cut = ($urandom_range(9) == 0) ? $urandom_range(nb - 1) : nb;
        for (int i = 0; i < cut; i++)
            send_frame_byte(8'($urandom_range(255)), 2, 2);
        if (cut < nb)
            send_noise($urandom_range(1, 10));
    endtask

    // receiver side: random stalls, calm stretches, one long hold on request
    initial
    begin
        int run;
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                run  = ($urandom_range(3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 8);
                hold = ($urandom_range(9) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 3);
                out_stall <= 1'b0;
                repeat (run) @(posedge clk);
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int stop_at;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        data_bit     <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= swnd_pkg::CFG_SYNC_MODE;
        cfg_data     <= '0;
        clear_deframer();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].listed)
                listed_bytes.push_back('{plan[i].exp_value, plan[i].exp_last});
            case (plan[i].kind)
                ROW_CFG:
                begin
                    wait_idle();
                    write_cfg(plan[i].idx, plan[i].arg);
                end
                ROW_SYNC: send_sync();
                ROW_BYTE: send_frame_byte(plan[i].arg[7:0], 0, 0);
                ROW_RAW:
                    for (int k = 0; k < plan[i].len; k++)
                        drive_bit(plan[i].arg[k]);
                default: ;
            endcase
        end

        stop_at = bits_sent + RANDOM_BITS;
        while (bits_sent < stop_at)
        begin
            wait_idle();
            write_cfg(swnd_pkg::CFG_SYNC_MODE, 16'($urandom_range(3) != 0));
            write_cfg(swnd_pkg::CFG_SYNC_PATTERN, 16'($urandom_range(16'hFFFF)));
            write_cfg(swnd_pkg::CFG_PACKET_BYTES,
                      16'(($urandom_range(7) == 0) ? $urandom_range(7, 24)
                                                   : $urandom_range(1, 6)));
            repeat ($urandom_range(1, 3)) send_packet();
        end

        // free mode so every framed byte comes out; the receiver holds off meanwhile
        wait_idle();
        write_cfg(swnd_pkg::CFG_SYNC_MODE, 16'd0);
        write_cfg(swnd_pkg::CFG_PACKET_BYTES, 16'd4);
        hold_req = 1'b1;
        wait (!hold_req);
        repeat (PRESS_BYTES) send_frame_byte(8'($urandom_range(255)), 2, 2);

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
